// ----- rtl/wsed_pkg.sv -----
// shared constants and controller/datapath interface types of the edge deque
`timescale 1ns / 1ps
`default_nettype none
package wsed_pkg;

  localparam int unsigned DefCapacity   = 64;
  localparam int unsigned DefVertexBits = 16;
  localparam int unsigned DefWeightBits = 32;

  // operation codes carried by the action field
  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_APPEND   = 3'd1,
    ACT_POP_BACK = 3'd2,
    ACT_PREPEND  = 3'd3,
    ACT_POP_FRNT = 3'd4,
    ACT_INSERT   = 3'd5,
    ACT_CONTAINS = 3'd6,
    ACT_NOP      = 3'd7
  } action_e;

  // per-cycle commands from controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic idx_zero;
    logic idx_one;
    logic idx_last;
    logic idx_inc;
    logic idx_dec;
    logic save_pos;
    logic wr_back;
    logic wr_front;
    logic wr_pos;
    logic wr_shift;
    logic pop_back;
    logic pop_front;
    logic set_found;
    logic set_empty;
    logic set_reject;
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    action_e action;
    logic    empty;
    logic    full;
    logic    w_lt;
    logic    w_gt;
    logic    match;
    logic    idx_lt_count;
    logic    idx_at_last;
    logic    idx_at_pos;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/weight_sorted_edge_deque.sv -----
// Edge deque with weight-ordered insert: one operation per transfer, one result each.
// Clear/append/prepend/rejects finish at dispatch, removes read one entry, contains scans
// from the front to the first match, ordered insert scans for the slot and shifts the tail.
// Throughput: one operation at a time; the next is taken the cycle after the result leaves.
// The store, with one write port and a registered read, needs a wait state per scanned or moved entry.
// Reset clears the fill count, head pointer and control; store contents are never cleared.
`timescale 1ns / 1ps
`default_nettype none
module weight_sorted_edge_deque #(
  parameter int unsigned CAPACITY    = wsed_pkg::DefCapacity,
  parameter int unsigned VERTEX_BITS = wsed_pkg::DefVertexBits,
  parameter int unsigned WEIGHT_BITS = wsed_pkg::DefWeightBits,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [2:0]                     action_i,
  input  wire [VERTEX_BITS-1:0]         edge_start_i,
  input  wire [VERTEX_BITS-1:0]         edge_end_i,
  input  wire signed [WEIGHT_BITS-1:0]  edge_weight_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [VERTEX_BITS-1:0]        out_start_o,
  output logic [VERTEX_BITS-1:0]        out_end_o,
  output logic signed [WEIGHT_BITS-1:0] out_weight_o,
  output logic                          was_empty_o,
  output logic                          found_o,
  output logic                          rejected_full_o,
  output logic [CW-1:0]                 occupancy_o
);

  wsed_pkg::cmd_t    cmd;
  wsed_pkg::status_t status;

  // sequencer
  wsed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // store and result datapath
  wsed_datapath #(
    .CAPACITY    (CAPACITY),
    .VERTEX_BITS (VERTEX_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .action_i        (action_i),
    .edge_start_i    (edge_start_i),
    .edge_end_i      (edge_end_i),
    .edge_weight_i   (edge_weight_i),
    .out_start_o     (out_start_o),
    .out_end_o       (out_end_o),
    .out_weight_o    (out_weight_o),
    .was_empty_o     (was_empty_o),
    .found_o         (found_o),
    .rejected_full_o (rejected_full_o),
    .occupancy_o     (occupancy_o)
  );

endmodule
`default_nettype wire

// ----- rtl/wsed_datapath.sv -----
// edge store memory, head/count pointers, scan index and result registers
`timescale 1ns / 1ps
`default_nettype none
module wsed_datapath #(
  parameter int unsigned CAPACITY    = wsed_pkg::DefCapacity,
  parameter int unsigned VERTEX_BITS = wsed_pkg::DefVertexBits,
  parameter int unsigned WEIGHT_BITS = wsed_pkg::DefWeightBits,
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire wsed_pkg::cmd_t           cmd_i,
  output wsed_pkg::status_t             status_o,
  input  wire [2:0]                     action_i,
  input  wire [VERTEX_BITS-1:0]         edge_start_i,
  input  wire [VERTEX_BITS-1:0]         edge_end_i,
  input  wire signed [WEIGHT_BITS-1:0]  edge_weight_i,
  output logic [VERTEX_BITS-1:0]        out_start_o,
  output logic [VERTEX_BITS-1:0]        out_end_o,
  output logic signed [WEIGHT_BITS-1:0] out_weight_o,
  output logic                          was_empty_o,
  output logic                          found_o,
  output logic                          rejected_full_o,
  output logic [CW-1:0]                 occupancy_o
);

  localparam int unsigned EW = 2 * VERTEX_BITS + WEIGHT_BITS;

  logic [EW-1:0] mem [CAPACITY];

  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q;
  logic [EW-1:0] rdata_q;

  logic [2:0]                    action_q;
  logic [VERTEX_BITS-1:0]        e_start_q;
  logic [VERTEX_BITS-1:0]        e_end_q;
  logic signed [WEIGHT_BITS-1:0] e_weight_q;

  logic [VERTEX_BITS-1:0]        res_start_q;
  logic [VERTEX_BITS-1:0]        res_end_q;
  logic signed [WEIGHT_BITS-1:0] res_weight_q;
  logic                          res_empty_q;
  logic                          res_found_q;
  logic                          res_reject_q;

  // logical position to physical slot of the circular store
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [CW-1:0] lpos);
    logic [CW:0] s;
    s = (CW + 1)'(head) + {1'b0, lpos};
    if (s >= (CW + 1)'(CAPACITY)) s = s - (CW + 1)'(CAPACITY);
    return s[IW-1:0];
  endfunction

  logic [EW-1:0] e_word;
  logic [IW-1:0] head_dec, head_inc;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          we;
  logic signed [WEIGHT_BITS-1:0] rd_weight;

  assign e_word    = {e_start_q, e_end_q, e_weight_q};
  assign rd_weight = rdata_q[WEIGHT_BITS-1:0];
  assign head_dec  = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
  assign head_inc  = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
  assign rd_addr   = phys(head_q, idx_q);

  // write port select
  always_comb begin
    we      = 1'b0;
    wr_addr = phys(head_q, count_q);
    wr_data = e_word;
    if (cmd_i.wr_back) begin
      we = 1'b1;
    end else if (cmd_i.wr_front) begin
      we      = 1'b1;
      wr_addr = head_dec;
    end else if (cmd_i.wr_pos) begin
      we      = 1'b1;
      wr_addr = phys(head_q, pos_q);
    end else if (cmd_i.wr_shift) begin
      we      = 1'b1;
      wr_addr = phys(head_q, idx_q + CW'(1));
      wr_data = rdata_q;
    end
  end

  // store with registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  // pointer and index next values
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.clear) count_d = '0;
    if (cmd_i.wr_back || cmd_i.wr_pos) count_d = count_q + CW'(1);
    if (cmd_i.wr_front) begin
      head_d  = head_dec;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop_back) count_d = count_q - CW'(1);
    if (cmd_i.pop_front) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.idx_zero) idx_d = '0;
    if (cmd_i.idx_one)  idx_d = CW'(1);
    if (cmd_i.idx_last) idx_d = count_q - CW'(1);
    if (cmd_i.idx_inc)  idx_d = idx_q + CW'(1);
    if (cmd_i.idx_dec)  idx_d = idx_q - CW'(1);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.save_pos) pos_q <= idx_q;
    if (cmd_i.load) begin
      action_q     <= action_i;
      e_start_q    <= edge_start_i;
      e_end_q      <= edge_end_i;
      e_weight_q   <= edge_weight_i;
      res_start_q  <= '0;
      res_end_q    <= '0;
      res_weight_q <= '0;
      res_empty_q  <= 1'b0;
      res_found_q  <= 1'b0;
      res_reject_q <= 1'b0;
    end
    if (cmd_i.pop_back || cmd_i.pop_front) begin
      res_start_q  <= rdata_q[EW-1 -: VERTEX_BITS];
      res_end_q    <= rdata_q[WEIGHT_BITS +: VERTEX_BITS];
      res_weight_q <= rd_weight;
    end
    if (cmd_i.set_found)  res_found_q  <= 1'b1;
    if (cmd_i.set_empty)  res_empty_q  <= 1'b1;
    if (cmd_i.set_reject) res_reject_q <= 1'b1;
  end

  // status toward the controller
  always_comb begin
    status_o.action       = wsed_pkg::action_e'(action_q);
    status_o.empty        = (count_q == '0);
    status_o.full         = (count_q == CW'(CAPACITY));
    status_o.w_lt         = (e_weight_q < rd_weight);
    status_o.w_gt         = (e_weight_q > rd_weight);
    status_o.match        = (rdata_q == e_word);
    status_o.idx_lt_count = (idx_q < count_q);
    status_o.idx_at_last  = (idx_q == count_q - CW'(1));
    status_o.idx_at_pos   = (idx_q == pos_q);
  end

  assign out_start_o     = res_start_q;
  assign out_end_o       = res_end_q;
  assign out_weight_o    = res_weight_q;
  assign was_empty_o     = res_empty_q;
  assign found_o         = res_found_q;
  assign rejected_full_o = res_reject_q;
  assign occupancy_o     = count_q;

endmodule
`default_nettype wire

// ----- rtl/wsed_ctrl.sv -----
// operation sequencer: handshakes, memory read waits, scan and shift loops
`timescale 1ns / 1ps
`default_nettype none
module wsed_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  input  wire wsed_pkg::status_t  status_i,
  output wsed_pkg::cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD_WAIT, S_POP, S_FRONT_WAIT, S_FRONT_CHK,
    S_SCAN_WAIT, S_SCAN_CHK, S_SH_WAIT, S_SH_WR, S_PLACE,
    S_CT_WAIT, S_CT_CHK, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  // command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_OUT;
        case (status_i.action)
          wsed_pkg::ACT_CLEAR: cmd_o.clear = 1'b1;
          wsed_pkg::ACT_APPEND: begin
            if (status_i.full) cmd_o.set_reject = 1'b1;
            else               cmd_o.wr_back    = 1'b1;
          end
          wsed_pkg::ACT_PREPEND: begin
            if (status_i.full) cmd_o.set_reject = 1'b1;
            else               cmd_o.wr_front   = 1'b1;
          end
          wsed_pkg::ACT_POP_BACK: begin
            if (status_i.empty) cmd_o.set_empty = 1'b1;
            else begin
              cmd_o.idx_last = 1'b1;
              state_d        = S_RD_WAIT;
            end
          end
          wsed_pkg::ACT_POP_FRNT: begin
            if (status_i.empty) cmd_o.set_empty = 1'b1;
            else begin
              cmd_o.idx_zero = 1'b1;
              state_d        = S_RD_WAIT;
            end
          end
          wsed_pkg::ACT_INSERT: begin
            if (status_i.full)       cmd_o.set_reject = 1'b1;
            else if (status_i.empty) cmd_o.wr_front   = 1'b1;
            else begin
              cmd_o.idx_zero = 1'b1;
              state_d        = S_FRONT_WAIT;
            end
          end
          wsed_pkg::ACT_CONTAINS: begin
            if (!status_i.empty) begin
              cmd_o.idx_zero = 1'b1;
              state_d        = S_CT_WAIT;
            end
          end
          default: ;
        endcase
      end
      S_RD_WAIT: state_d = S_POP;
      S_POP: begin
        if (status_i.action == wsed_pkg::ACT_POP_BACK) cmd_o.pop_back  = 1'b1;
        else                                           cmd_o.pop_front = 1'b1;
        state_d = S_OUT;
      end
      // ordered insert: compare against front
      S_FRONT_WAIT: state_d = S_FRONT_CHK;
      S_FRONT_CHK: begin
        if (status_i.w_lt) begin
          cmd_o.wr_front = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.idx_one = 1'b1;
          state_d       = S_SCAN_WAIT;
        end
      end
      // ordered insert: forward scan for the slot
      S_SCAN_WAIT: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (status_i.idx_lt_count && status_i.w_gt) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_WAIT;
        end else begin
          cmd_o.save_pos = 1'b1;
          if (!status_i.idx_lt_count) begin
            state_d = S_PLACE;
          end else begin
            cmd_o.idx_last = 1'b1;
            state_d        = S_SH_WAIT;
          end
        end
      end
      // ordered insert: move tail up one slot, back to front
      S_SH_WAIT: state_d = S_SH_WR;
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        if (status_i.idx_at_pos) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_SH_WAIT;
        end
      end
      S_PLACE: begin
        cmd_o.wr_pos = 1'b1;
        state_d      = S_OUT;
      end
      // membership scan
      S_CT_WAIT: state_d = S_CT_CHK;
      S_CT_CHK: begin
        if (status_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_OUT;
        end else if (status_i.idx_at_last) begin
          state_d = S_OUT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_CT_WAIT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_d == S_OUT);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
